// File: hdl/i2cseq_pkg.sv
// Shared types, codes and constants for the two-wire bus master command sequencer.
// No dependencies; the controller, datapath and top level import this package.
package i2cseq_pkg;

    // Default number of entries in each ring.
    localparam int RING_DEPTH_DEF = 16;

    localparam int BYTE_W = 8;

    // Input operation selector (carried on the slave-side tuser).
    localparam logic [1:0] OP_PUSH_CMD = 2'd0;
    localparam logic [1:0] OP_PUSH_TAG = 2'd1;
    localparam logic [1:0] OP_STATUS   = 2'd2;

    // Bus status codes after masking the low three bits.
    localparam logic [7:0] BS_MASK         = 8'hF8;
    localparam logic [7:0] BS_START        = 8'h08;
    localparam logic [7:0] BS_RESTART      = 8'h10;
    localparam logic [7:0] BS_SLA_W_ACK    = 8'h18;
    localparam logic [7:0] BS_SLA_W_NACK   = 8'h20;
    localparam logic [7:0] BS_DATA_TX_ACK  = 8'h28;
    localparam logic [7:0] BS_DATA_TX_NACK = 8'h30;
    localparam logic [7:0] BS_SLA_R_ACK    = 8'h40;
    localparam logic [7:0] BS_SLA_R_NACK   = 8'h48;
    localparam logic [7:0] BS_DATA_RX_ACK  = 8'h50;
    localparam logic [7:0] BS_DATA_RX_NACK = 8'h58;

    // Special command bytes.
    localparam logic [7:0] CMD_STOP    = 8'hFF;
    localparam logic [7:0] CMD_RESTART = 8'hFE;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_TX        = 3'd1,
        ACT_STOP      = 3'd2,
        ACT_RESTART   = 3'd3,
        ACT_READ_NACK = 3'd4,
        ACT_ABORT     = 3'd5
    } action_t;

    // Decoded class of an input beat.
    typedef enum logic [2:0] {
        K_NOP      = 3'd0,
        K_PUSH_CMD = 3'd1,
        K_PUSH_TAG = 3'd2,
        K_TX       = 3'd3,
        K_DECIDE   = 3'd4,
        K_READ     = 3'd5,
        K_NACK     = 3'd6,
        K_ABORT    = 3'd7
    } kind_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_FETCH = 1'b1
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic in_ready;
        logic capture;
        logic push_cmd;
        logic push_tag;
        logic pop_cmd;
        logic pop_tag;
        logic load_imm;
        logic load_fetched;
    } seq_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic  in_valid;
        logic  out_free;
        kind_t kind;
    } seq_sts_t;

    typedef struct packed {
        action_t            action;
        logic [BYTE_W-1:0]  tx_byte;
        logic               ack_enable;
        logic               read_valid;
        logic [BYTE_W-1:0]  read_dest;
        logic [BYTE_W-1:0]  read_byte;
    } result_t;

endpackage

// File: hdl/i2cseq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module i2cseq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/i2cseq_ctrl.sv
// Controller state machine of the command sequencer: sequences accept, ring fetch
// and result load. Depends on i2cseq_pkg.
module i2cseq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  i2cseq_pkg::seq_sts_t  sts,
    output i2cseq_pkg::seq_cmd_t  cmd
);

    import i2cseq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   needs_fetch;

    assign needs_fetch = (sts.kind == K_TX) || (sts.kind == K_DECIDE) || (sts.kind == K_READ);
    assign accept      = (state_reg == ST_IDLE) && sts.in_valid && sts.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && needs_fetch)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = sts.out_free;
                cmd.capture  = accept;
                cmd.push_cmd = accept && (sts.kind == K_PUSH_CMD);
                cmd.push_tag = accept && (sts.kind == K_PUSH_TAG);
                cmd.pop_cmd  = accept && needs_fetch;
                cmd.pop_tag  = accept && (sts.kind == K_READ);
                cmd.load_imm = accept && !needs_fetch;
            end
            ST_FETCH:
            begin
                cmd.load_fetched = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    // A popping status always enters the fetch state to read the ring.
    a_pop_enters_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_cmd |=> (state_reg == ST_FETCH))
        else $error("pop did not enter fetch");

    // A fetched result is held back while the output register stays full.
    a_fetch_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH && !sts.out_free) |=> (state_reg == ST_FETCH))
        else $error("fetch left while output busy");
`endif

endmodule

// File: hdl/i2cseq_dp.sv
// Datapath of the command sequencer: ring pointers, ring RAMs, decode and output
// register. Depends on i2cseq_pkg and i2cseq_ram.
module i2cseq_dp #(
    parameter int RING_DEPTH = i2cseq_pkg::RING_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  i2cseq_pkg::seq_cmd_t  cmd,
    output i2cseq_pkg::seq_sts_t  sts,
    input  logic                  in_valid,
    input  logic [1:0]            operation,
    input  logic [7:0]            cmd_byte,
    input  logic [7:0]            read_tag,
    input  logic [7:0]            bus_status,
    input  logic [7:0]            rx_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output i2cseq_pkg::result_t   out_result
);

    import i2cseq_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    logic [PTR_W-1:0] cmd_wr_ptr_reg, cmd_wr_ptr_next;
    logic [PTR_W-1:0] cmd_rd_ptr_reg, cmd_rd_ptr_next;
    logic [PTR_W-1:0] tag_wr_ptr_reg, tag_wr_ptr_next;
    logic [PTR_W-1:0] tag_rd_ptr_reg, tag_rd_ptr_next;

    kind_t       kind;
    kind_t       kind_reg;
    logic [7:0]  rx_reg;
    logic [7:0]  cmd_rdata;
    logic [7:0]  tag_rdata;
    result_t     imm_result;
    result_t     fetched_result;
    result_t     out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        begin
            n = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
            return n;
        end
    endfunction

    // Input decode.
    always_comb
    begin
        kind = K_NOP;
        unique case (operation)
            OP_PUSH_CMD: kind = K_PUSH_CMD;
            OP_PUSH_TAG: kind = K_PUSH_TAG;
            OP_STATUS:
            begin
                unique case (bus_status & BS_MASK)
                    BS_START, BS_RESTART:                       kind = K_TX;
                    BS_SLA_W_ACK, BS_DATA_TX_ACK, BS_DATA_TX_NACK: kind = K_DECIDE;
                    BS_DATA_RX_ACK, BS_DATA_RX_NACK:            kind = K_READ;
                    BS_SLA_R_ACK:                               kind = K_NACK;
                    BS_SLA_W_NACK, BS_SLA_R_NACK:               kind = K_ABORT;
                    default:                                    kind = K_NOP;
                endcase
            end
            default: kind = K_NOP;
        endcase
    end

    assign sts.in_valid = in_valid;
    assign sts.out_free = !out_valid_reg || out_ready;
    assign sts.kind     = kind;

    // Pointers advance before the access, so the RAM address is the next value.
    assign cmd_wr_ptr_next = cmd.push_cmd ? advance(cmd_wr_ptr_reg) : cmd_wr_ptr_reg;
    assign tag_wr_ptr_next = cmd.push_tag ? advance(tag_wr_ptr_reg) : tag_wr_ptr_reg;
    assign cmd_rd_ptr_next = cmd.pop_cmd  ? advance(cmd_rd_ptr_reg) : cmd_rd_ptr_reg;
    assign tag_rd_ptr_next = cmd.pop_tag  ? advance(tag_rd_ptr_reg) : tag_rd_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_wr_ptr_reg <= '0;
            cmd_rd_ptr_reg <= '0;
            tag_wr_ptr_reg <= '0;
            tag_rd_ptr_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cmd_wr_ptr_reg <= cmd_wr_ptr_next;
            cmd_rd_ptr_reg <= cmd_rd_ptr_next;
            tag_wr_ptr_reg <= tag_wr_ptr_next;
            tag_rd_ptr_reg <= tag_rd_ptr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    i2cseq_ram #(.WIDTH(BYTE_W), .DEPTH(RING_DEPTH)) u_cmd_ring (
        .clk   (clk),
        .we    (cmd.push_cmd),
        .waddr (cmd_wr_ptr_next),
        .wdata (cmd_byte),
        .raddr (cmd_rd_ptr_next),
        .rdata (cmd_rdata)
    );

    i2cseq_ram #(.WIDTH(BYTE_W), .DEPTH(RING_DEPTH)) u_tag_ring (
        .clk   (clk),
        .we    (cmd.push_tag),
        .waddr (tag_wr_ptr_next),
        .wdata (read_tag),
        .raddr (tag_rd_ptr_next),
        .rdata (tag_rdata)
    );

    // Payload captured with the beat for use once the ring data is back.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            rx_reg   <= rx_data;
        end
        out_reg <= out_next;
    end

    always_comb
    begin
        imm_result = '0;
        unique case (kind)
            K_NACK:  imm_result.action = ACT_READ_NACK;
            K_ABORT: imm_result.action = ACT_ABORT;
            default: imm_result.action = ACT_NONE;
        endcase
    end

    always_comb
    begin
        fetched_result = '0;
        unique case (kind_reg)
            K_TX:
            begin
                fetched_result.action     = ACT_TX;
                fetched_result.tx_byte    = cmd_rdata;
                fetched_result.ack_enable = 1'b1;
            end
            K_DECIDE, K_READ:
            begin
                fetched_result.ack_enable = 1'b1;
                if (cmd_rdata == CMD_STOP)
                begin
                    fetched_result.action = ACT_STOP;
                end
                else if (cmd_rdata == CMD_RESTART)
                begin
                    fetched_result.action = ACT_RESTART;
                end
                else
                begin
                    fetched_result.action  = ACT_TX;
                    fetched_result.tx_byte = cmd_rdata;
                end
                if (kind_reg == K_READ)
                begin
                    fetched_result.read_valid = 1'b1;
                    fetched_result.read_dest  = tag_rdata;
                    fetched_result.read_byte  = rx_reg;
                end
            end
            default: fetched_result = '0;
        endcase
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        priority if (cmd.load_imm)
        begin
            out_next       = imm_result;
            out_valid_next = 1'b1;
        end
        else if (cmd.load_fetched)
        begin
            out_next       = fetched_result;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

`ifndef SYNTHESIS
    // Any load leaves a beat waiting at the output.
    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_imm || cmd.load_fetched) |=> out_valid_reg)
        else $error("load did not present a beat");

    // The command read pointer moves only on a pop.
    a_rd_ptr_only_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.pop_cmd |=> $stable(cmd_rd_ptr_reg))
        else $error("command read pointer moved without a pop");
`endif

endmodule

// File: hdl/i2c_master_command_sequencer_unit.sv
// Top level of the two-wire bus master command sequencer.
// Depends on i2cseq_pkg, i2cseq_ctrl, i2cseq_dp and i2cseq_ram.
//
// Usage: each slave-side beat carries an operation on s_tuser: push a command
// byte into the command ring, push a destination tag into the tag ring, or
// report a bus status. Every accepted beat produces exactly one master-side
// beat, in order. For a status the block pops the next command and answers
// with the bus action to take (transmit, stop, repeated start); read statuses
// also pop a tag and hand back the received byte with it. Address-missing-ack
// statuses answer at once with abort, read-address-ack with read-without-ack.
// Pushes and statuses that pop nothing load the output register on acceptance;
// statuses that pop a ring pass through the fetch state first, because the
// ring RAMs have a registered read port, and take no new beat until it ends.
// Other beats are taken at one beat per cycle while m_tready stays high.
// The rings have no full or empty checks and wrap silently; popping an entry
// never written returns undefined data.
// Reset clears the ring pointers and empties the output register; the ring
// contents are left undefined. A stalled receiver (m_tready low) holds the
// result in the output register and drops s_tready until it is taken; one new
// beat may be accepted in the cycle the waiting result is taken.
module i2c_master_command_sequencer_unit #(
    parameter int RING_DEPTH = i2cseq_pkg::RING_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // cmd_byte[7:0], read_tag[15:8], bus_status[23:16],
                                   // rx_data[31:24]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // tx_byte[7:0], ack_enable[8], read_valid[9],
                                   // read_dest[17:10], read_byte[25:18], zero[31:26]
    output logic [2:0]  m_tuser    // action[2:0]
);

    import i2cseq_pkg::*;

    seq_cmd_t cmd;
    seq_sts_t sts;
    result_t  result;

    i2cseq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    i2cseq_dp #(.RING_DEPTH(RING_DEPTH)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_valid   (s_tvalid),
        .operation  (s_tuser),
        .cmd_byte   (s_tdata[7:0]),
        .read_tag   (s_tdata[15:8]),
        .bus_status (s_tdata[23:16]),
        .rx_data    (s_tdata[31:24]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign s_tready = cmd.in_ready;
    assign m_tuser  = result.action;
    assign m_tdata  = {6'd0, result.read_byte, result.read_dest, result.read_valid,
                       result.ack_enable, result.tx_byte};

endmodule
